// ===== hdl/trv_pkg.sv =====
`default_nettype none

package trv_pkg;

  localparam int unsigned IDX_W      = 20;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned START_W    = 24;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned MIX_W      = 16;
  localparam int unsigned QP_W       = 12;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam int unsigned CHANNELS_DEF = 2;

  localparam logic [QP_W-1:0]  QP_RST     = 12'd100;
  localparam logic [ENV_W-1:0] ATTACK_RST = 16'd432;
  localparam logic [ENV_W-1:0] DECAY_RST  = 16'd384;

  // voice = round(mag*g*81*2^13 / (q*d*25)) = floor((N*2^14 + D) / 2D)
  localparam int unsigned GAIN_NUM  = 81;
  localparam int unsigned GAIN_W    = 7;
  localparam int unsigned SCALE_DEN = 25;
  localparam int unsigned SCALE_W   = 5;
  localparam int unsigned ROUND_SH  = 14;

  localparam int unsigned MOD_NUM_W = IDX_W - 2;
  localparam int unsigned PROD_W    = QP_W + ENV_W;
  localparam int unsigned N_W       = PROD_W + GAIN_W;
  localparam int unsigned D_W       = PROD_W + SCALE_W;
  localparam int unsigned X_W       = N_W + ROUND_SH + 1;
  localparam int unsigned Y_W       = D_W + 1;
  localparam int unsigned VOICE_W   = 15;
  localparam logic [VOICE_W-1:0] VOICE_MAX = 15'd26542;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_QUARTER = 2'd0,
    CFG_ATTACK  = 2'd1,
    CFG_DECAY   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic                    ch;
    logic [START_W-1:0]      start;
    logic [LEN_W-1:0]        len;
    logic [IDX_W-1:0]        idx;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic                    ch;
    logic signed [MIX_W-1:0] mix;
    logic                    neg;
  } voice_side_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic                    ch;
    logic signed [MIX_W-1:0] mix;
    logic [ENV_W-1:0]        g;
    logic [ENV_W-1:0]        d;
    logic [1:0]              ilo;
  } mod_side_t;

endpackage

`default_nettype wire

// ===== hdl/trv_div_pipe.sv =====
`default_nettype none

module trv_div_pipe #(
  parameter int unsigned NUM_W  = 18,
  parameter int unsigned DEN_W  = 12,
  parameter int unsigned QUO_W  = 18,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire trv_pkg::pipe_ctl_t    ctl_i,
  input  wire logic [NUM_W-1:0]      num_i,
  input  wire logic [DEN_W-1:0]      den_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  output logic                       vld_o,
  output logic [QUO_W-1:0]           quo_o,
  output logic [DEN_W-1:0]           rem_o,
  output logic [SIDE_W-1:0]          side_o
);

  import trv_pkg::*;

  localparam int unsigned W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              vld_q  [QUO_W];
  logic [W-1:0]      rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  logic              vld_d  [QUO_W];
  logic [W-1:0]      rem_d  [QUO_W];
  logic [DEN_W-1:0]  den_d  [QUO_W];
  logic [QUO_W-1:0]  quo_d  [QUO_W];
  logic [SIDE_W-1:0] side_d [QUO_W];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [W-1:0]     rem_in;
    logic [W-1:0]     den_sh;
    logic [QUO_W-1:0] quo_in;
    logic             ge;
    if (k == 0) begin : g_first
      assign vld_d[k]  = ctl_i.vld;
      assign rem_in    = W'(num_i);
      assign den_d[k]  = den_i;
      assign quo_in    = '0;
      assign side_d[k] = side_i;
    end else begin : g_next
      assign vld_d[k]  = vld_q[k-1];
      assign rem_in    = rem_q[k-1];
      assign den_d[k]  = den_q[k-1];
      assign quo_in    = quo_q[k-1];
      assign side_d[k] = side_q[k-1];
    end
    assign den_sh   = W'(den_d[k]) << (QUO_W - 1 - k);
    assign ge       = rem_in >= den_sh;
    assign rem_d[k] = ge ? rem_in - den_sh : rem_in;
    assign quo_d[k] = (quo_in << 1) | QUO_W'(ge);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QUO_W; k++) vld_q[k] <= 1'b0;
    end else if (ctl_i.en) begin
      for (int k = 0; k < QUO_W; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_d[k];
        quo_q[k]  <= quo_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign rem_o  = rem_q[QUO_W-1][DEN_W-1:0];
  assign side_o = side_q[QUO_W-1];

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QUO_W-1] |-> rem_q[QUO_W-1] < W'(den_q[QUO_W-1]))
    else $error("remainder not below divisor");

  a_first_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.en |=> vld_q[0] == $past(ctl_i.vld))
    else $error("first stage valid lost");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.en |=> $stable(vld_q[QUO_W-1]) && $stable(quo_q[QUO_W-1]))
    else $error("last stage moved during stall");
`endif

endmodule

`default_nettype wire

// ===== hdl/triangle_voice_ar_envelope.sv =====
// path: stage 0 register, phase modulo divider, triangle and multiply registers, gain quotient divider, output register
// throughput: one word per cycle while the output is not stalled, set by the fully pipelined dividers
//   (18 stages for the phase modulo, 15 for the gain quotient)
// an input skid register takes one more word while the output is stalled
// reset: config registers return to 100 / 432 / 384, all valid bits and the skid clear
`default_nettype none

module triangle_voice_ar_envelope #(
  parameter int unsigned CHANNELS = trv_pkg::CHANNELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [trv_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [trv_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // frame_index, note_length, note_start, mix_in
  input  wire logic [trv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // channel
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // sample_address, mix_out, clipped, zero pad
  output logic [trv_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // channel_out
  output logic                                 m_axis_tuser
);

  import trv_pkg::*;

  // configuration
  logic [QP_W-1:0]  quarter_q;
  logic [ENV_W-1:0] attack_q, decay_q;
  logic [QP_W-1:0]  q_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q <= QP_RST;
      attack_q  <= ATTACK_RST;
      decay_q   <= DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_QUARTER: quarter_q <= cfg_wdata_i[QP_W-1:0];
        CFG_ATTACK:  attack_q  <= cfg_wdata_i[ENV_W-1:0];
        CFG_DECAY:   decay_q   <= cfg_wdata_i[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_eff = (quarter_q == '0) ? QP_W'(1) : quarter_q;

  // pipeline control
  logic      en;
  logic      out_vld_q;
  pipe_ctl_t mod_ctl, div_ctl;

  assign en = m_axis_tready || !out_vld_q;

  // input skid
  in_word_t in_word, skid_q, src;
  logic     skid_vld_q, in_acc, src_vld;

  assign in_word.idx   = s_axis_tdata[IDX_W-1:0];
  assign in_word.len   = s_axis_tdata[IDX_W+LEN_W-1:IDX_W];
  assign in_word.start = s_axis_tdata[IDX_W+LEN_W+START_W-1:IDX_W+LEN_W];
  assign in_word.mix   = s_axis_tdata[IN_TDATA_W-1:IDX_W+LEN_W+START_W];
  assign in_word.ch    = s_axis_tuser;

  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign src           = skid_vld_q ? skid_q : in_word;
  assign src_vld       = skid_vld_q || in_acc;

  // envelope branch select
  logic                    att_hit, rel_hit, past_end, chan_ok;
  logic signed [LEN_W+1:0] rel_lim;
  logic [LEN_W-1:0]        rem_len;
  logic [ENV_W-1:0]        env_g, env_d;
  mod_side_t               st0_side_d;

  always_comb begin
    att_hit  = src.idx < IDX_W'(attack_q);
    rel_lim  = $signed({2'b00, src.len}) - $signed((LEN_W+2)'(decay_q));
    rel_hit  = $signed({2'b00, src.idx}) > rel_lim;
    past_end = src.idx >= src.len;
    rem_len  = src.len - src.idx;
    chan_ok  = 32'(src.ch) < 32'(CHANNELS);
    if (att_hit) begin
      env_g = src.idx[ENV_W-1:0];
      env_d = attack_q;
    end else if (rel_hit) begin
      env_g = past_end ? '0 : rem_len[ENV_W-1:0];
      env_d = past_end ? ENV_W'(1) : decay_q;
    end else begin
      env_g = ENV_W'(1);
      env_d = ENV_W'(1);
    end
    if (!chan_ok) env_g = '0;
    st0_side_d.addr = src.start + ADDR_W'(src.idx);
    st0_side_d.ch   = src.ch;
    st0_side_d.mix  = src.mix;
    st0_side_d.g    = env_g;
    st0_side_d.d    = env_d;
    st0_side_d.ilo  = src.idx[1:0];
  end

  logic                 st0_vld_q;
  logic [MOD_NUM_W-1:0] st0_num_q;
  mod_side_t            st0_side_q;

  // phase modulo: i mod 4q = ((i >> 2) mod q) * 4 + i[1:0]
  logic            mod_vld;
  logic [QP_W-1:0] mod_rem;
  mod_side_t       mod_side;

  assign mod_ctl = '{en: en, vld: st0_vld_q};

  trv_div_pipe #(
    .NUM_W  (MOD_NUM_W),
    .DEN_W  (QP_W),
    .QUO_W  (MOD_NUM_W),
    .SIDE_W ($bits(mod_side_t))
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mod_ctl),
    .num_i  (st0_num_q),
    .den_i  (q_eff),
    .side_i (st0_side_q),
    .vld_o  (mod_vld),
    .quo_o  (),
    .rem_o  (mod_rem),
    .side_o (mod_side)
  );

  // triangle value
  logic [QP_W:0]          two_q;
  logic [QP_W+1:0]        three_q, tri_a;
  logic signed [QP_W+2:0] tri_t, tri_abs;
  voice_side_t            t_side_d;

  always_comb begin
    two_q   = {q_eff, 1'b0};
    three_q = (QP_W+2)'(q_eff) + (QP_W+2)'(two_q);
    tri_a   = {mod_rem, mod_side.ilo};
    if (tri_a < (QP_W+2)'(two_q)) begin
      tri_t = $signed((QP_W+3)'(q_eff)) - $signed({1'b0, tri_a});
    end else begin
      tri_t = $signed({1'b0, tri_a}) - $signed({1'b0, three_q});
    end
    tri_abs        = tri_t[QP_W+2] ? -tri_t : tri_t;
    t_side_d.addr  = mod_side.addr;
    t_side_d.ch    = mod_side.ch;
    t_side_d.mix   = mod_side.mix;
    t_side_d.neg   = tri_t[QP_W+2];
  end

  logic             t_vld_q, m1_vld_q, m2_vld_q, m3_vld_q;
  logic [QP_W-1:0]  t_mag_q;
  logic [ENV_W-1:0] t_g_q, t_d_q;
  voice_side_t      t_side_q, m1_side_q, m2_side_q, m3_side_q;
  logic [PROD_W-1:0] p1_q, p2_q;
  logic [N_W-1:0]   n_q;
  logic [D_W-1:0]   dd_q;
  logic [X_W-1:0]   x_q;
  logic [Y_W-1:0]   y_q;

  // rounded gain quotient
  logic               div_vld;
  logic [VOICE_W-1:0] div_quo;
  voice_side_t        div_side;

  assign div_ctl = '{en: en, vld: m3_vld_q};

  trv_div_pipe #(
    .NUM_W  (X_W),
    .DEN_W  (Y_W),
    .QUO_W  (VOICE_W),
    .SIDE_W ($bits(voice_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (x_q),
    .den_i  (y_q),
    .side_i (m3_side_q),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .rem_o  (),
    .side_o (div_side)
  );

  // mix and saturate
  logic signed [MIX_W-1:0] voice;
  logic signed [MIX_W:0]   sum;
  logic signed [MIX_W-1:0] mix_d;
  logic                    clip_d;

  always_comb begin
    voice = div_side.neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    sum   = $signed({div_side.mix[MIX_W-1], div_side.mix}) + $signed({voice[MIX_W-1], voice});
    if (sum > $signed((MIX_W+1)'(2**(MIX_W-1) - 1))) begin
      mix_d  = {1'b0, {(MIX_W-1){1'b1}}};
      clip_d = 1'b1;
    end else if (sum < -$signed((MIX_W+1)'(2**(MIX_W-1)))) begin
      mix_d  = {1'b1, {(MIX_W-1){1'b0}}};
      clip_d = 1'b1;
    end else begin
      mix_d  = sum[MIX_W-1:0];
      clip_d = 1'b0;
    end
  end

  logic [ADDR_W-1:0]       out_addr_q;
  logic                    out_ch_q, out_clip_q;
  logic signed [MIX_W-1:0] out_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
      st0_vld_q  <= 1'b0;
      t_vld_q    <= 1'b0;
      m1_vld_q   <= 1'b0;
      m2_vld_q   <= 1'b0;
      m3_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (en) begin
        skid_vld_q <= 1'b0;
        st0_vld_q  <= src_vld;
        t_vld_q    <= mod_vld;
        m1_vld_q   <= t_vld_q;
        m2_vld_q   <= m1_vld_q;
        m3_vld_q   <= m2_vld_q;
        out_vld_q  <= div_vld;
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_acc) skid_q <= in_word;
    if (en) begin
      st0_num_q  <= src.idx[IDX_W-1:2];
      st0_side_q <= st0_side_d;
      t_mag_q    <= tri_abs[QP_W-1:0];
      t_g_q      <= mod_side.g;
      t_d_q      <= mod_side.d;
      t_side_q   <= t_side_d;
      p1_q       <= PROD_W'(t_mag_q) * PROD_W'(t_g_q);
      p2_q       <= PROD_W'(q_eff) * PROD_W'(t_d_q);
      m1_side_q  <= t_side_q;
      n_q        <= N_W'(p1_q) * N_W'(GAIN_NUM);
      dd_q       <= D_W'(p2_q) * D_W'(SCALE_DEN);
      m2_side_q  <= m1_side_q;
      x_q        <= (X_W'(n_q) << ROUND_SH) + X_W'(dd_q);
      y_q        <= {dd_q, 1'b0};
      m3_side_q  <= m2_side_q;
      out_addr_q <= div_side.addr;
      out_ch_q   <= div_side.ch;
      out_mix_q  <= mix_d;
      out_clip_q <= clip_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-ADDR_W-MIX_W-1){1'b0}}, out_clip_q, out_mix_q, out_addr_q};
  assign m_axis_tuser  = out_ch_q;

`ifndef NO_ASSERTIONS
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(!en))
    else $error("skid filled while pipeline advancing");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && en |=> st0_vld_q && !skid_vld_q)
    else $error("skid word not moved into pipeline");

  a_mod_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(mod_vld) && $stable(t_vld_q))
    else $error("pipeline moved during stall");

  a_voice_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> div_quo <= VOICE_MAX)
    else $error("voice magnitude above full gain");

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_clip_q |->
      (out_mix_q == $signed({1'b0, {(MIX_W-1){1'b1}}})) ||
      (out_mix_q == $signed({1'b1, {(MIX_W-1){1'b0}}})))
    else $error("clip flag without rail value");
`endif

endmodule

`default_nettype wire
